FILE: rtl/drift_attitude_target_step_unit_defines.svh
// Assertion macros shared by the attitude target step RTL.
`ifndef DRIFT_ATTITUDE_TARGET_STEP_UNIT_DEFINES_SVH
`define DRIFT_ATTITUDE_TARGET_STEP_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during rst.
`define DATS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off during rst.
`define DATS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/dats_pkg.sv
// Types, constants and helper functions for the attitude target step unit.
package dats_pkg;

  localparam int MUL_W  = 33;
  localparam int PROD_W = 66;

  // floor(2^32 / 100) and floor(2^45 / 15625); one correction step follows each
  localparam logic [25:0] RECIP_100   = 26'd42949672;
  localparam logic [31:0] RECIP_15625 = 32'd2251799813;
  localparam logic [6:0]  DIV_100     = 7'd100;
  localparam logic [13:0] DIV_15625   = 14'd15625;

  // yaw rate magnitude reaches the cap once the product passes 90000 * 500000
  localparam logic [36:0] YAW_SAT_X    = 37'd45000000000;
  localparam logic [16:0] YAW_RATE_MAX = 17'd90000;

  localparam logic [12:0] FWD_SPAN  = 13'd5000;
  localparam logic [12:0] FWD_CAP   = 13'd2000;
  localparam logic [12:0] TILT_CAP  = 13'd4500;
  localparam logic signed [13:0] TILT_CAP_S = 14'sd4500;
  localparam logic [6:0]  FILT_OLD   = 7'd96;
  localparam int          FILT_SHIFT = 10;   // stick * 256 * 4
  localparam logic [11:0] BRAKE_STEP = 12'd3;

  typedef enum logic [1:0] {
    REG_YAW_GAIN    = 2'd0,
    REG_SPEED_GAIN  = 2'd1,
    REG_SPEED_LIMIT = 2'd2
  } cfg_reg_t;

  typedef enum logic [4:0] {
    S_IDLE, S_RV1, S_RV2, S_PV1, S_PV2, S_VEL, S_FILT, S_FWD, S_SPAN,
    S_FQ, S_FQ2, S_FC, S_YX, S_YS, S_YQ, S_YC, S_RA, S_RM, S_RQ, S_RQ2,
    S_RC, S_RS, S_BM, S_BQ, S_BQ2, S_BC, S_FIN
  } state_t;

  typedef struct packed {
    logic signed [MUL_W-1:0] a;
    logic signed [MUL_W-1:0] b;
  } mul_op_t;

  // divide by 2^14, rounding toward zero
  function automatic logic signed [19:0] trunc_q14(input logic signed [33:0] v);
    logic signed [33:0] b;
    b = v + (v[33] ? 34'sd16383 : 34'sd0);
    return b[33:14];
  endfunction

  function automatic logic signed [12:0] clamp_lim(input logic signed [19:0] v,
                                                  input logic [11:0] lim);
    logic signed [19:0] hi;
    logic signed [19:0] lo;
    logic signed [12:0] r;
    hi = $signed({8'b0, lim});
    lo = -hi;
    if (v > hi) r = hi[12:0];
    else if (v < lo) r = lo[12:0];
    else r = v[12:0];
    return r;
  endfunction

  // magnitude and sign back to a saturated angle
  function automatic logic signed [13:0] sat_mag(input logic [21:0] m, input logic neg);
    logic [12:0] mm;
    logic signed [13:0] s;
    mm = (m > {9'b0, TILT_CAP}) ? TILT_CAP : m[12:0];
    s = $signed({1'b0, mm});
    return neg ? -s : s;
  endfunction

  function automatic logic signed [13:0] clamp_angle(input logic signed [13:0] v);
    logic signed [13:0] r;
    if (v > TILT_CAP_S) r = TILT_CAP_S;
    else if (v < -TILT_CAP_S) r = -TILT_CAP_S;
    else r = v;
    return r;
  endfunction

  // quotient estimate is one low at most
  function automatic logic corr_100(input logic [27:0] n, input logic [27:0] qm);
    logic [27:0] r;
    r = n - qm;
    return r >= {21'b0, DIV_100};
  endfunction

endpackage

FILE: rtl/dats_mul.sv
// Shared signed multiplier with registered product.
module dats_mul (
  input  logic                                clk,
  input  dats_pkg::mul_op_t                   op,
  output logic signed [dats_pkg::PROD_W-1:0]  p
);
  import dats_pkg::*;

  always_ff @(posedge clk) begin
    p <= $signed(op.a) * $signed(op.b);
  end

endmodule

FILE: rtl/drift_attitude_target_step_unit.sv
// Top level of the attitude target step unit: sequencer, datapath and ports.
//
// One control tick per input item. An engaged item passes every state from
// acceptance until the block is ready again, with the result registered at the
// output in the last one, S_FIN; a disengaged item goes from S_IDLE to S_FIN.
// A single 33x33 signed multiplier with a registered product serves the
// sequencer for the velocity rotation, the filter, the gains and every
// constant division (reciprocal multiply, then a one-step correction).
// in_stall is high while the sequencer runs. A new item is taken while the
// previous result still waits at the output; the sequencer holds its last step
// until the output register is free. Configuration writes apply at once.
`include "drift_attitude_target_step_unit_defines.svh"

module drift_attitude_target_step_unit (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [11:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [13:0] roll_lean,
  input  logic signed [13:0] pitch_lean,
  input  logic signed [13:0] yaw_stick,
  input  logic signed [15:0] vel_north,
  input  logic signed [15:0] vel_east,
  input  logic signed [15:0] cos_yaw,
  input  logic signed [15:0] sin_yaw,
  input  logic               engaged,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [13:0] roll_target,
  output logic signed [13:0] pitch_target,
  output logic signed [17:0] yaw_rate_target,
  output logic               valid_res
);
  import dats_pkg::*;

  state_t state, state_next;

  logic [10:0] yaw_gain;
  logic [10:0] speed_gain;
  logic [11:0] speed_limit;

  logic signed [21:0] roll_filter;
  logic [10:0]        brake_gain;

  // latched item
  logic [13:0]        rl_mag;
  logic               rl_neg;
  logic signed [13:0] pl_r;
  logic signed [13:0] ys_r;
  logic signed [15:0] vn_r, ve_r, cy_r, sy_r;
  logic               eng_r;

  // work registers
  logic signed [33:0] acc;
  logic signed [33:0] rsum;
  logic signed [19:0] rvr, pvr;
  logic signed [12:0] rvc, pvc;
  logic [12:0]        span;
  logic [27:0]        dmag;
  logic               dneg;
  logic [21:0]        qd;
  logic [25:0]        ta;
  logic [36:0]        x;
  logic               ysat;
  logic [17:0]        qy;
  logic [16:0]        ymag;
  logic signed [21:0] rfn;
  logic [10:0]        bgn;
  logic signed [17:0] yaw_r;
  logic signed [13:0] roll_r;

  mul_op_t               mop;
  logic signed [65:0]    p;

  logic               out_free;
  logic signed [33:0] acc_abs;
  logic signed [65:0] p_abs;
  logic signed [19:0] pv_abs;
  logic [12:0]        fwd;
  logic signed [22:0] qd_s;
  logic [31:0]        yrem;
  logic [11:0]        bg3;
  logic [17:0]        yq_fix;

  dats_mul u_mul (
    .clk (clk),
    .op  (mop),
    .p   (p)
  );

  assign out_free = !out_valid || !out_stall;
  assign acc_abs  = acc[33] ? -acc : acc;
  assign p_abs    = p[65] ? -p : p;
  assign pv_abs   = pvr[19] ? -pvr : pvr;
  assign fwd      = (pv_abs > $signed({7'b0, FWD_CAP})) ? FWD_CAP : pv_abs[12:0];
  assign qd_s     = $signed({1'b0, qd});
  assign yrem     = x[36:5] - p[31:0];
  assign bg3      = {1'b0, brake_gain} + BRAKE_STEP;
  assign yq_fix   = qy + {17'b0, (yrem >= {18'b0, DIV_15625})};

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

  // sequencer and multiplier operand select
  always_comb begin
    state_next = state;
    mop = '0;
    in_stall = (state != S_IDLE);
    case (state)
      S_IDLE:  if (in_valid) state_next = engaged ? S_RV1 : S_FIN;
      S_RV1: begin
        mop.a = $signed({{17{ve_r[15]}}, ve_r});
        mop.b = $signed({{17{cy_r[15]}}, cy_r});
        state_next = S_RV2;
      end
      S_RV2: begin
        mop.a = $signed({{17{vn_r[15]}}, vn_r});
        mop.b = $signed({{17{sy_r[15]}}, sy_r});
        state_next = S_PV1;
      end
      S_PV1: begin
        mop.a = $signed({{17{ve_r[15]}}, ve_r});
        mop.b = $signed({{17{sy_r[15]}}, sy_r});
        state_next = S_PV2;
      end
      S_PV2: begin
        mop.a = $signed({{17{vn_r[15]}}, vn_r});
        mop.b = $signed({{17{cy_r[15]}}, cy_r});
        state_next = S_VEL;
      end
      S_VEL: begin
        mop.a = $signed({{11{roll_filter[21]}}, roll_filter});
        mop.b = $signed({26'b0, FILT_OLD});
        state_next = S_FILT;
      end
      S_FILT:  state_next = S_FWD;
      S_FWD: begin
        mop.a = $signed({{20{rvc[12]}}, rvc});
        mop.b = $signed({22'b0, speed_gain});
        state_next = S_SPAN;
      end
      S_SPAN: begin
        mop.a = $signed({19'b0, rl_mag});
        mop.b = $signed({20'b0, span});
        state_next = S_FQ;
      end
      S_FQ, S_RQ, S_BQ: begin
        mop.a = $signed({5'b0, dmag});
        mop.b = $signed({7'b0, RECIP_100});
        case (state)
          S_FQ:    state_next = S_FQ2;
          S_RQ:    state_next = S_RQ2;
          default: state_next = S_BQ2;
        endcase
      end
      S_FQ2, S_RQ2, S_BQ2: begin
        mop.a = $signed({11'b0, p[53:32]});
        mop.b = $signed({26'b0, DIV_100});
        case (state)
          S_FQ2:   state_next = S_FC;
          S_RQ2:   state_next = S_RC;
          default: state_next = S_BC;
        endcase
      end
      S_FC: begin
        mop.a = $signed({7'b0, ta});
        mop.b = $signed({22'b0, yaw_gain});
        state_next = S_YX;
      end
      S_YX:    state_next = S_YS;
      S_YS: begin
        mop.a = $signed({1'b0, x[36:5]});
        mop.b = $signed({1'b0, RECIP_15625});
        state_next = S_YQ;
      end
      S_YQ: begin
        mop.a = $signed({15'b0, p[62:45]});
        mop.b = $signed({19'b0, DIV_15625});
        state_next = S_YC;
      end
      S_YC: begin
        mop.a = $signed({{11{rfn[21]}}, rfn});
        mop.b = $signed({26'b0, DIV_100});
        state_next = S_RA;
      end
      S_RA:    state_next = S_RM;
      S_RM:    state_next = S_RQ;
      S_RC:    state_next = S_RS;
      S_RS: begin
        mop.a = $signed({{20{pvc[12]}}, pvc});
        mop.b = $signed({22'b0, bgn});
        state_next = S_BM;
      end
      S_BM:    state_next = S_BQ;
      S_BC:    state_next = S_FIN;
      S_FIN:   if (out_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      yaw_gain    <= 11'd450;
      speed_gain  <= 11'd800;
      speed_limit <= 12'd560;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_YAW_GAIN:    yaw_gain    <= cfg_data[10:0];
        REG_SPEED_GAIN:  speed_gain  <= cfg_data[10:0];
        REG_SPEED_LIMIT: speed_limit <= cfg_data;
        default: ;
      endcase
    end
  end

  // filter and brake state, committed with the result
  always_ff @(posedge clk) begin
    if (rst) begin
      roll_filter <= '0;
      brake_gain  <= '0;
    end else if (state == S_FIN && out_free && eng_r) begin
      roll_filter <= rfn;
      brake_gain  <= bgn;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (state == S_FIN && out_free) out_valid <= 1'b1;
    else if (!out_stall) out_valid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (state == S_FIN && out_free) begin
      if (eng_r) begin
        roll_target     <= roll_r;
        pitch_target    <= (pl_r == '0) ? sat_mag(qd, dneg) : clamp_angle(pl_r);
        yaw_rate_target <= yaw_r;
        valid_res       <= 1'b1;
      end else begin
        roll_target     <= '0;
        pitch_target    <= '0;
        yaw_rate_target <= '0;
        valid_res       <= 1'b0;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: if (in_valid) begin
        rl_mag <= roll_lean[13] ? 14'(-roll_lean) : roll_lean;
        rl_neg <= roll_lean[13];
        pl_r   <= pitch_lean;
        ys_r   <= yaw_stick;
        vn_r   <= vel_north;
        ve_r   <= vel_east;
        cy_r   <= cos_yaw;
        sy_r   <= sin_yaw;
        eng_r  <= engaged;
      end
      S_RV2:  acc  <= $signed(p[33:0]);
      S_PV1:  rsum <= acc - $signed(p[33:0]);
      S_PV2:  acc  <= $signed(p[33:0]);
      S_VEL: begin
        acc <= acc + $signed(p[33:0]);
        rvr <= trunc_q14(rsum);
      end
      S_FILT: begin
        pvr <= trunc_q14(acc);
        rvc <= clamp_lim(rvr, speed_limit);
        acc <= $signed(p[33:0]) + ($signed({{20{ys_r[13]}}, ys_r}) <<< FILT_SHIFT);
      end
      S_FWD: begin
        pvc  <= clamp_lim(pvr, speed_limit);
        span <= FWD_SPAN - fwd;
        dmag <= acc_abs[27:0];
        dneg <= acc[33];
      end
      S_SPAN: acc <= $signed(p[33:0]);
      S_FQ:   ta  <= p[25:0];
      S_FQ2, S_RQ2, S_BQ2: qd <= p[53:32];
      S_FC, S_RC, S_BC: begin
        qd <= qd + {21'b0, corr_100(dmag, p[27:0])};
        if (state == S_RC) begin
          if (pl_r == '0) bgn <= (bg3 > {1'b0, speed_gain}) ? speed_gain : bg3[10:0];
          else bgn <= '0;
        end
      end
      S_YX: begin
        x   <= p[36:0];
        rfn <= dneg ? 22'(-qd_s) : 22'(qd_s);
      end
      S_YS:   ysat <= (x >= YAW_SAT_X);
      S_YQ:   qy   <= p[62:45];
      S_YC:   ymag <= ysat ? YAW_RATE_MAX : yq_fix[16:0];
      S_RA: begin
        // A = 100*filter - 256*roll_speed*gain
        acc   <= $signed(p[33:0]) - (acc <<< 8);
        yaw_r <= rl_neg ? -$signed({1'b0, ymag}) : $signed({1'b0, ymag});
      end
      S_RM: begin
        dmag <= {2'b0, acc_abs[33:8]};
        dneg <= acc[33];
      end
      S_RS:   roll_r <= sat_mag(qd, dneg);
      S_BM: begin
        dmag <= p_abs[27:0];
        dneg <= p[65];
      end
      default: ;
    endcase
  end

  `DATS_ASSERT_NEXT(a_accept_busy, in_valid && !in_stall, in_stall, "item accepted but still ready")
  `DATS_ASSERT_NEXT(a_fin_load, state == S_FIN && out_free, out_valid && !in_stall, "result not loaded")
  `DATS_ASSERT_NOW(a_off_zero, out_valid && !valid_res, roll_target == '0 && pitch_target == '0 && yaw_rate_target == '0, "disengaged result not zero")
  `DATS_ASSERT_NOW(a_angle_range, out_valid && valid_res, roll_target <= TILT_CAP_S && roll_target >= -TILT_CAP_S && pitch_target <= TILT_CAP_S && pitch_target >= -TILT_CAP_S, "target out of range")
  `DATS_ASSERT_NOW(a_brake_cap, state == S_RS, bgn <= speed_gain, "brake gain above speed gain")

endmodule
